// File: src/uft_pkg.sv
`timescale 1ns / 1ps

package uft_pkg;

   localparam int IDX_W = 12;
   localparam int CSR_W = 13;
   localparam int LIM_W = 17;

   localparam logic [CSR_W-1:0] CSR_RESET  = 13'd4096;
   localparam logic             CMD_UNION  = 1'b1;

   typedef logic [IDX_W-1:0] uft_index_type;

   typedef struct packed {
      logic          linked;
      uft_index_type parent;
   } uft_entry_type;

   typedef struct packed {
      logic          rd_en;
      logic          wr_en;
      uft_entry_type wr_data;
   } uft_mem_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_A,
      ST_WALK_B,
      ST_RESP
   } uft_state_type;

endpackage

// File: src/uft_req_if.sv
`timescale 1ns / 1ps

interface uft_req_if;
   logic                 valid;
   logic                 ready;
   logic                 cmd;
   uft_pkg::uft_index_type first_index;
   uft_pkg::uft_index_type second_index;

   modport source (output valid, output cmd, output first_index, output second_index,
                   input ready);
   modport sink (input valid, input cmd, input first_index, input second_index,
                 output ready);
endinterface

// File: src/uft_rsp_if.sv
`timescale 1ns / 1ps

interface uft_rsp_if;
   logic                 valid;
   logic                 ready;
   uft_pkg::uft_index_type root_index;
   logic                 merged;
   logic                 error;

   modport source (output valid, output root_index, output merged, output error,
                   input ready);
   modport sink (input valid, input root_index, input merged, input error,
                 output ready);
endinterface

// File: src/union_find_table.sv
`timescale 1ns / 1ps

// Disjoint-set table of parent links held in one single-port-read, single-port-write
// memory of NODES entries with a registered read. A find transaction walks parent links
// from first_index to its root, one memory read per link, and returns the root; a union
// walks both nodes and, when the roots differ, links the second root under the first and
// sets merged. An index not below nodes_in_use (or NODES) returns error with nothing
// changed. A find reads one entry per link from the node to its root, a union walks the
// first node and then the second, and a rejected transaction goes straight to the result
// state without a read; each then loads the output register. One transaction is
// worked at a time while the previous result may still wait at the output register.
// After reset a clearing pass marks every node as a root; requests are held off during
// it, while csr writes are taken at any time.
module union_find_table #(
   parameter int NODES = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   uft_req_if.sink                   req_port,
   uft_rsp_if.source                 rsp_port,
   input  logic                      csr_wr_en,
   input  logic [uft_pkg::CSR_W-1:0] csr_wr_data
);

   localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;

   uft_pkg::uft_mem_cmd_type mem_cmd;
   uft_pkg::uft_entry_type   rd_data;
   logic [AW-1:0]            rd_addr;
   logic [AW-1:0]            wr_addr;

   uft_ctrl #(
      .NODES(NODES),
      .AW   (AW)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_port   (req_port),
      .rsp_port   (rsp_port),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .mem_cmd    (mem_cmd),
      .rd_addr    (rd_addr),
      .wr_addr    (wr_addr),
      .rd_data    (rd_data)
   );

   uft_store #(
      .NODES(NODES),
      .AW   (AW)
   ) u_store (
      .clock  (clock),
      .mem_cmd(mem_cmd),
      .rd_addr(rd_addr),
      .wr_addr(wr_addr),
      .rd_data(rd_data)
   );

endmodule

// File: src/uft_store.sv
`timescale 1ns / 1ps

module uft_store #(
   parameter int NODES = 4096,
   parameter int AW    = 12
) (
   input  logic                    clock,
   input  uft_pkg::uft_mem_cmd_type mem_cmd,
   input  logic [AW-1:0]           rd_addr,
   input  logic [AW-1:0]           wr_addr,
   output uft_pkg::uft_entry_type  rd_data
);

   uft_pkg::uft_entry_type mem [NODES];
   uft_pkg::uft_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_cmd.wr_en) begin
         mem[wr_addr] <= mem_cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/uft_ctrl.sv
`timescale 1ns / 1ps

module uft_ctrl #(
   parameter int NODES = 4096,
   parameter int AW    = 12
) (
   input  logic                           clock,
   input  logic                           reset,
   uft_req_if.sink                        req_port,
   uft_rsp_if.source                      rsp_port,
   input  logic                           csr_wr_en,
   input  logic [uft_pkg::CSR_W-1:0]      csr_wr_data,
   output uft_pkg::uft_mem_cmd_type       mem_cmd,
   output logic [AW-1:0]                  rd_addr,
   output logic [AW-1:0]                  wr_addr,
   input  uft_pkg::uft_entry_type         rd_data
);

   localparam logic [uft_pkg::LIM_W-1:0] NODES_W = uft_pkg::LIM_W'(NODES);
   localparam logic [AW-1:0]             LAST_ADDR = AW'(NODES - 1);

   uft_pkg::uft_state_type state_ff, state_in;
   logic [uft_pkg::CSR_W-1:0] csr_ff, csr_in;
   logic [AW-1:0]             clr_ff, clr_in;
   logic                      cmd_ff, cmd_in;
   uft_pkg::uft_index_type    b_ff, b_in;
   uft_pkg::uft_index_type    cur_ff, cur_in;
   uft_pkg::uft_index_type    res_root_ff, res_root_in;
   logic                      res_merged_ff, res_merged_in;
   logic                      res_error_ff, res_error_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   uft_pkg::uft_index_type    rsp_root_ff, rsp_root_in;
   logic                      rsp_merged_ff, rsp_merged_in;
   logic                      rsp_error_ff, rsp_error_in;
   logic                      req_ready;
   logic                      first_bad;
   logic                      second_bad;
   logic                      req_bad;
   logic                      rsp_free;

   assign first_bad = ({1'b0, req_port.first_index} >= csr_ff) ||
                      (uft_pkg::LIM_W'(req_port.first_index) >= NODES_W);
   assign second_bad = ({1'b0, req_port.second_index} >= csr_ff) ||
                       (uft_pkg::LIM_W'(req_port.second_index) >= NODES_W);
   assign req_bad = first_bad || (req_port.cmd == uft_pkg::CMD_UNION && second_bad);
   assign rsp_free = !rsp_valid_ff || rsp_port.ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         uft_pkg::ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = uft_pkg::ST_IDLE;
            end
         end
         uft_pkg::ST_IDLE: begin
            if (req_port.valid) begin
               state_in = req_bad ? uft_pkg::ST_RESP : uft_pkg::ST_WALK_A;
            end
         end
         uft_pkg::ST_WALK_A: begin
            if (!rd_data.linked) begin
               state_in = (cmd_ff == uft_pkg::CMD_UNION) ? uft_pkg::ST_WALK_B
                                                         : uft_pkg::ST_RESP;
            end
         end
         uft_pkg::ST_WALK_B: begin
            if (!rd_data.linked) begin
               state_in = uft_pkg::ST_RESP;
            end
         end
         uft_pkg::ST_RESP: begin
            if (rsp_free) begin
               state_in = uft_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = uft_pkg::ST_CLEAR;
         end
      endcase
   end

   // outputs and datapath
   always_comb begin
      mem_cmd       = '0;
      rd_addr       = AW'(cur_ff);
      wr_addr       = clr_ff;
      req_ready     = 1'b0;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      b_in          = b_ff;
      cur_in        = cur_ff;
      res_root_in   = res_root_ff;
      res_merged_in = res_merged_ff;
      res_error_in  = res_error_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_root_in   = rsp_root_ff;
      rsp_merged_in = rsp_merged_ff;
      rsp_error_in  = rsp_error_ff;
      csr_in        = csr_wr_en ? csr_wr_data : csr_ff;
      case (state_ff)
         uft_pkg::ST_CLEAR: begin
            // every entry starts out as a root
            mem_cmd.wr_en = 1'b1;
            clr_in        = clr_ff + 1'b1;
         end
         uft_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_port.valid) begin
               cmd_in        = req_port.cmd;
               b_in          = req_port.second_index;
               cur_in        = req_port.first_index;
               res_merged_in = 1'b0;
               res_error_in  = req_bad;
               res_root_in   = '0;
               if (!req_bad) begin
                  mem_cmd.rd_en = 1'b1;
                  rd_addr       = AW'(req_port.first_index);
               end
            end
         end
         uft_pkg::ST_WALK_A: begin
            if (rd_data.linked) begin
               cur_in        = rd_data.parent;
               mem_cmd.rd_en = 1'b1;
               rd_addr       = AW'(rd_data.parent);
            end else begin
               res_root_in = cur_ff;
               if (cmd_ff == uft_pkg::CMD_UNION) begin
                  cur_in        = b_ff;
                  mem_cmd.rd_en = 1'b1;
                  rd_addr       = AW'(b_ff);
               end
            end
         end
         uft_pkg::ST_WALK_B: begin
            if (rd_data.linked) begin
               cur_in        = rd_data.parent;
               mem_cmd.rd_en = 1'b1;
               rd_addr       = AW'(rd_data.parent);
            end else if (cur_ff != res_root_ff) begin
               // link second root under first root
               mem_cmd.wr_en          = 1'b1;
               mem_cmd.wr_data.linked = 1'b1;
               mem_cmd.wr_data.parent = res_root_ff;
               wr_addr                = AW'(cur_ff);
               res_merged_in          = 1'b1;
            end
         end
         uft_pkg::ST_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_root_in   = res_root_ff;
               rsp_merged_in = res_merged_ff;
               rsp_error_in  = res_error_ff;
            end
         end
         default: begin
            clr_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= uft_pkg::ST_CLEAR;
         clr_ff       <= '0;
         csr_ff       <= uft_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      b_ff          <= b_in;
      cur_ff        <= cur_in;
      res_root_ff   <= res_root_in;
      res_merged_ff <= res_merged_in;
      res_error_ff  <= res_error_in;
      rsp_root_ff   <= rsp_root_in;
      rsp_merged_ff <= rsp_merged_in;
      rsp_error_ff  <= rsp_error_in;
   end

   assign req_port.ready      = req_ready;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.root_index = rsp_root_ff;
   assign rsp_port.merged     = rsp_merged_ff;
   assign rsp_port.error      = rsp_error_ff;

endmodule
